### rtl/core/gasp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gasp_pkg
// Shared types and constants of the grid path search core.
// ----------------------------------------------------------------------------
package gasp_pkg;

	localparam int GRID_DIM_DEF = 8;
	localparam int COORD_W      = 3;
	localparam int COUNT_W      = 4;
	localparam int COST_W       = 7;
	localparam int F_W          = 8;
	localparam int DIR_W        = 2;
	localparam int CFG_IDX_W    = 1;

	localparam logic [COUNT_W-1:0] ROW_COUNT_RST = 4'd8;
	localparam logic [COUNT_W-1:0] COL_COUNT_RST = 4'd8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'b1;

	// action codes
	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	// move directions
	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

	typedef struct packed {
		logic               action;
		logic [COORD_W-1:0] cell_row;
		logic [COORD_W-1:0] cell_col;
		logic               cell_blocked;
		logic [COORD_W-1:0] start_row;
		logic [COORD_W-1:0] start_col;
		logic [COORD_W-1:0] goal_row;
		logic [COORD_W-1:0] goal_col;
	} in_word_t;

	typedef struct packed {
		logic [COORD_W-1:0] path_row;
		logic [COORD_W-1:0] path_col;
		logic               found;
		logic               last;
	} out_word_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_SCAN,
		ST_PICK,
		ST_NB_RD,
		ST_NB_WR,
		ST_BT_CHK,
		ST_BT_STEP,
		ST_EM_RD,
		ST_EM_LD,
		ST_NOPATH
	} state_t;

	typedef struct packed {
		logic seed;
		logic scan_clr;
		logic scan_step;
		logic pick_close;
		logic nb_issue;
		logic nb_update;
		logic nb_next;
		logic bt_init;
		logic bt_issue;
		logic bt_push;
		logic em_init;
		logic em_issue;
		logic em_load;
		logic nopath_load;
	} dp_cmd_t;

	typedef struct packed {
		logic start_out;
		logic scan_done;
		logic best_valid;
		logic best_is_goal;
		logic nb_ok;
		logic nb_last;
		logic bt_done;
		logic bt_bad;
		logic em_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

### rtl/core/gasp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gasp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gasp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/core/gasp_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gasp_ctrl
// Sequencer: seed, scan for best open cell, expand neighbours, trace, emit.
// ----------------------------------------------------------------------------
module gasp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             search_go,
	input  wire gasp_pkg::dp_sts_t sts,
	output      gasp_pkg::dp_cmd_t cmd,
	output      logic             idle
);
	import gasp_pkg::*;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (search_go) state_nxt = ST_SEED;
			end
			ST_SEED: begin
				state_nxt = sts.start_out ? ST_NOPATH : ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_nxt = ST_PICK;
			end
			ST_PICK: begin
				if (!sts.best_valid) state_nxt = ST_NOPATH;
				else if (sts.best_is_goal) state_nxt = ST_BT_CHK;
				else state_nxt = ST_NB_RD;
			end
			ST_NB_RD: begin
				if (sts.nb_ok) state_nxt = ST_NB_WR;
				else if (sts.nb_last) state_nxt = ST_SCAN;
			end
			ST_NB_WR: begin
				state_nxt = sts.nb_last ? ST_SCAN : ST_NB_RD;
			end
			ST_BT_CHK: begin
				state_nxt = sts.bt_done ? ST_EM_RD : ST_BT_STEP;
			end
			ST_BT_STEP: begin
				state_nxt = sts.bt_bad ? ST_EM_RD : ST_BT_CHK;
			end
			ST_EM_RD: begin
				state_nxt = ST_EM_LD;
			end
			ST_EM_LD: begin
				if (sts.out_free) state_nxt = sts.em_last ? ST_IDLE : ST_EM_RD;
			end
			ST_NOPATH: begin
				if (sts.out_free) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		idle = 1'b0;
		unique case (state_q)
			ST_IDLE: idle = 1'b1;
			ST_SEED: begin
				cmd.seed     = 1'b1;
				cmd.scan_clr = 1'b1;
			end
			ST_SCAN: cmd.scan_step = 1'b1;
			ST_PICK: begin
				if (sts.best_valid && sts.best_is_goal) cmd.bt_init = 1'b1;
				else if (sts.best_valid) cmd.pick_close = 1'b1;
			end
			ST_NB_RD: begin
				if (sts.nb_ok) begin
					cmd.nb_issue = 1'b1;
				end else if (sts.nb_last) begin
					cmd.scan_clr = 1'b1;
				end else begin
					cmd.nb_next = 1'b1;
				end
			end
			ST_NB_WR: begin
				cmd.nb_update = 1'b1;
				cmd.nb_next   = 1'b1;
				cmd.scan_clr  = sts.nb_last;
			end
			ST_BT_CHK: begin
				if (sts.bt_done) cmd.em_init = 1'b1;
				else cmd.bt_issue = 1'b1;
			end
			ST_BT_STEP: begin
				if (sts.bt_bad) cmd.em_init = 1'b1;
				else cmd.bt_push = 1'b1;
			end
			ST_EM_RD: cmd.em_issue = 1'b1;
			ST_EM_LD: cmd.em_load = sts.out_free;
			ST_NOPATH: cmd.nopath_load = sts.out_free;
			default: idle = 1'b0;
		endcase
	end
endmodule
`default_nettype wire

### rtl/core/gasp_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gasp_dp
// Datapath: grid and set bit maps, cost/parent/path memories, output word.
// ----------------------------------------------------------------------------
module gasp_dp #(
	parameter int GRID_DIM = gasp_pkg::GRID_DIM_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_acc,
	input  wire gasp_pkg::in_word_t                  in_word,
	input  wire logic                               cfg_wen,
	input  wire logic [gasp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [gasp_pkg::COUNT_W-1:0]        cfg_data,
	input  wire gasp_pkg::dp_cmd_t                   cmd,
	output      gasp_pkg::dp_sts_t                   sts,
	input  wire logic                               out_stall,
	output      logic                               out_valid,
	output      gasp_pkg::out_word_t                 out_word
);
	import gasp_pkg::*;

	// cell address is {row, col}; row-major order matches the tie order
	localparam int IDX_W = 2 * COORD_W;
	localparam int CELLS = 1 << IDX_W;
	localparam int CNT_W = $clog2(CELLS + 1);
	localparam logic [COUNT_W-1:0] DIM_C  = COUNT_W'(GRID_DIM);
	localparam logic [CNT_W-1:0]   CELLS_C = CNT_W'(CELLS);

	// configuration
	logic [COUNT_W-1:0] row_count_q, col_count_q, rows_eff, cols_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_COUNT_RST;
			col_count_q <= COL_COUNT_RST;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_ROW_COUNT: row_count_q <= cfg_data;
				REG_COL_COUNT: col_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_eff = (row_count_q > DIM_C) ? DIM_C : row_count_q;
	assign cols_eff = (col_count_q > DIM_C) ? DIM_C : col_count_q;

	// search endpoints
	logic [COORD_W-1:0] sr_q, sc_q, gr_q, gc_q;
	logic [IDX_W-1:0]   start_idx;

	always_ff @(posedge clk) begin
		if (in_acc && in_word.action == ACT_SEARCH) begin
			sr_q <= in_word.start_row;
			sc_q <= in_word.start_col;
			gr_q <= in_word.goal_row;
			gc_q <= in_word.goal_col;
		end
	end

	assign start_idx = {sr_q, sc_q};
	assign sts.start_out = ({1'b0, sr_q} >= rows_eff) || ({1'b0, sc_q} >= cols_eff);

	// bit maps
	logic [CELLS-1:0] blocked_q, open_q, closed_q;
	logic             load_in;
	logic [IDX_W-1:0] load_idx;

	assign load_in  = ({1'b0, in_word.cell_row} < DIM_C) && ({1'b0, in_word.cell_col} < DIM_C);
	assign load_idx = {in_word.cell_row, in_word.cell_col};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_q <= '0;
		end else if (in_acc && in_word.action == ACT_LOAD && load_in) begin
			blocked_q[load_idx] <= in_word.cell_blocked;
		end
	end

	// memories
	logic              cost_we, cost_re;
	logic [IDX_W-1:0]  cost_waddr, cost_raddr;
	logic [COST_W-1:0] cost_wdata, cost_rdata;
	logic              par_we;
	logic [DIR_W-1:0]  par_rdata;
	logic              stk_we;
	logic [IDX_W-1:0]  stk_waddr, stk_raddr, stk_wdata, stk_rdata;

	// scan
	logic [CNT_W-1:0]  idx_q;
	logic              pend_v_s1;
	logic [IDX_W-1:0]  pend_idx_s1;
	logic              best_v_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [F_W-1:0]    bf_q, f_cur;
	logic [COST_W-1:0] bg_q;
	logic [COORD_W-1:0] p_row, p_col, d_row, d_col;
	logic              scan_issue, take;

	assign scan_issue = cmd.scan_step && (idx_q < CELLS_C);
	assign p_row = pend_idx_s1[IDX_W-1:COORD_W];
	assign p_col = pend_idx_s1[COORD_W-1:0];
	assign d_row = (p_row > gr_q) ? p_row - gr_q : gr_q - p_row;
	assign d_col = (p_col > gc_q) ? p_col - gc_q : gc_q - p_col;
	assign f_cur = {1'b0, cost_rdata} + F_W'(d_row) + F_W'(d_col);
	assign take  = pend_v_s1 && open_q[pend_idx_s1] &&
		(!best_v_q || f_cur < bf_q || (f_cur == bf_q && cost_rdata > bg_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			pend_v_s1 <= 1'b0;
			best_v_q  <= 1'b0;
		end else if (cmd.scan_clr) begin
			idx_q     <= '0;
			pend_v_s1 <= 1'b0;
			best_v_q  <= 1'b0;
		end else begin
			pend_v_s1 <= scan_issue;
			if (scan_issue) idx_q <= idx_q + 1'b1;
			if (take) best_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (scan_issue) pend_idx_s1 <= idx_q[IDX_W-1:0];
		if (take) begin
			best_idx_q <= pend_idx_s1;
			bf_q       <= f_cur;
			bg_q       <= cost_rdata;
		end
	end

	assign sts.scan_done  = (idx_q == CELLS_C);
	assign sts.best_valid = best_v_q;

	logic [COORD_W-1:0] b_row, b_col;
	assign b_row = best_idx_q[IDX_W-1:COORD_W];
	assign b_col = best_idx_q[COORD_W-1:0];
	assign sts.best_is_goal = (b_row == gr_q) && (b_col == gc_q);

	// neighbour expansion
	logic [DIR_W-1:0]   nb_d_q;
	logic [IDX_W-1:0]   ni_q, ni;
	logic [COORD_W-1:0] n_row, n_col;
	logic               nb_in, nb_write;
	logic [COST_W-1:0]  ng;

	always_comb begin
		n_row = b_row;
		n_col = b_col;
		nb_in = 1'b0;
		case (nb_d_q)
			DIR_UP: begin
				n_row = b_row - 1'b1;
				nb_in = (b_row != '0);
			end
			DIR_DOWN: begin
				n_row = b_row + 1'b1;
				nb_in = ({1'b0, b_row} + 1'b1) < rows_eff;
			end
			DIR_LEFT: begin
				n_col = b_col - 1'b1;
				nb_in = (b_col != '0);
			end
			default: begin
				n_col = b_col + 1'b1;
				nb_in = ({1'b0, b_col} + 1'b1) < cols_eff;
			end
		endcase
	end

	assign ni          = {n_row, n_col};
	assign sts.nb_ok   = nb_in && !blocked_q[ni] && !closed_q[ni];
	assign sts.nb_last = (nb_d_q == DIR_RIGHT);
	assign ng          = bg_q + 1'b1;
	assign nb_write    = cmd.nb_update && (!open_q[ni_q] || ng < cost_rdata);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_d_q <= '0;
		end else if (cmd.pick_close) begin
			nb_d_q <= '0;
		end else if (cmd.nb_next) begin
			nb_d_q <= nb_d_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nb_issue) ni_q <= ni;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= '0;
			closed_q <= '0;
		end else if (cmd.seed) begin
			open_q   <= '0;
			closed_q <= '0;
			if (!sts.start_out) open_q[start_idx] <= 1'b1;
		end else if (cmd.pick_close) begin
			open_q[best_idx_q]   <= 1'b0;
			closed_q[best_idx_q] <= 1'b1;
		end else if (nb_write) begin
			open_q[ni_q] <= 1'b1;
		end
	end

	assign cost_we    = (cmd.seed && !sts.start_out) || nb_write;
	assign cost_waddr = cmd.seed ? start_idx : ni_q;
	assign cost_wdata = cmd.seed ? '0 : ng;
	assign cost_re    = scan_issue || cmd.nb_issue;
	assign cost_raddr = cmd.nb_issue ? ni : idx_q[IDX_W-1:0];
	assign par_we     = nb_write;

	gasp_ram #(.WIDTH(COST_W), .DEPTH(CELLS)) u_cost (
		.clk   (clk),
		.we    (cost_we),
		.waddr (cost_waddr),
		.wdata (cost_wdata),
		.re    (cost_re),
		.raddr (cost_raddr),
		.rdata (cost_rdata)
	);

	// back-trace
	logic [IDX_W-1:0]   cur_q, prev_idx;
	logic [CNT_W-1:0]   n_q, k_q, em_pos;
	logic [COORD_W-1:0] c_row, c_col, pv_row, pv_col;
	logic               bt_bad;

	assign c_row = cur_q[IDX_W-1:COORD_W];
	assign c_col = cur_q[COORD_W-1:0];

	always_comb begin
		pv_row = c_row;
		pv_col = c_col;
		bt_bad = 1'b0;
		case (par_rdata)
			DIR_UP: begin
				pv_row = c_row + 1'b1;
				bt_bad = ({1'b0, c_row} + 1'b1) >= DIM_C;
			end
			DIR_DOWN: begin
				pv_row = c_row - 1'b1;
				bt_bad = (c_row == '0);
			end
			DIR_LEFT: begin
				pv_col = c_col + 1'b1;
				bt_bad = ({1'b0, c_col} + 1'b1) >= DIM_C;
			end
			default: begin
				pv_col = c_col - 1'b1;
				bt_bad = (c_col == '0);
			end
		endcase
	end

	assign sts.bt_bad  = bt_bad;
	assign prev_idx    = {pv_row, pv_col};
	assign sts.bt_done = (cur_q == start_idx) || (n_q == CELLS_C);

	gasp_ram #(.WIDTH(DIR_W), .DEPTH(CELLS)) u_parent (
		.clk   (clk),
		.we    (par_we),
		.waddr (ni_q),
		.wdata (nb_d_q),
		.re    (cmd.bt_issue),
		.raddr (cur_q),
		.rdata (par_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
			k_q <= '0;
		end else begin
			if (cmd.bt_init) n_q <= CNT_W'(1);
			else if (cmd.bt_push) n_q <= n_q + 1'b1;
			if (cmd.em_init) k_q <= '0;
			else if (cmd.em_load) k_q <= k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.bt_init) cur_q <= best_idx_q;
		else if (cmd.bt_push) cur_q <= prev_idx;
	end

	assign stk_we    = cmd.bt_init || cmd.bt_push;
	assign stk_waddr = cmd.bt_init ? '0 : n_q[IDX_W-1:0];
	assign stk_wdata = cmd.bt_init ? best_idx_q : prev_idx;
	assign em_pos    = n_q - 1'b1 - k_q;
	assign stk_raddr = em_pos[IDX_W-1:0];
	assign sts.em_last = (k_q == n_q - 1'b1);

	gasp_ram #(.WIDTH(IDX_W), .DEPTH(CELLS)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (cmd.em_issue),
		.raddr (stk_raddr),
		.rdata (stk_rdata)
	);

	// output word
	logic out_valid_q;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.em_load || cmd.nopath_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.em_load) begin
			out_word.path_row <= stk_rdata[IDX_W-1:COORD_W];
			out_word.path_col <= stk_rdata[COORD_W-1:0];
			out_word.found    <= 1'b1;
			out_word.last     <= sts.em_last;
		end else if (cmd.nopath_load) begin
			out_word.path_row <= '0;
			out_word.path_col <= '0;
			out_word.found    <= 1'b0;
			out_word.last     <= 1'b1;
		end
	end
endmodule
`default_nettype wire

### rtl/core/grid_astar_path_search_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_astar_path_search_core
// A* shortest path on a four-neighbour grid, Manhattan heuristic.
// ----------------------------------------------------------------------------
// Input words (in_valid/in_stall): action 0 writes one obstacle bit;
// action 1 starts a search from start to goal. While a search runs,
// in_stall stays high.
// Output words (out_valid/out_stall): the path from start to goal, one cell
// per word, last marking the goal; or one word with found clear if the goal
// cannot be reached. A stalled word holds; the next word waits in the
// emitter until the output register frees.
// Each expansion sweeps all 64 cost entries through the single-read cost
// memory to pick the best open cell, then checks its four neighbours.
// The path is then traced back from the goal through the parent memory
// and emitted word by word, start first.
// row_count/col_count are written on cfg_wen (index 0 and 1); the user
// must write them only while idle, the block does not enforce this.
// Reset clears the obstacle map (all cells free), sets both counts to 8
// and empties the output register.
// ----------------------------------------------------------------------------
module grid_astar_path_search_core #(
	parameter int GRID_DIM = gasp_pkg::GRID_DIM_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output      logic                          in_stall,
	input  wire gasp_pkg::in_word_t             in_word,
	output      logic                          out_valid,
	input  wire logic                          out_stall,
	output      gasp_pkg::out_word_t            out_word,
	input  wire logic                          cfg_wen,
	input  wire logic [gasp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gasp_pkg::COUNT_W-1:0]   cfg_data
);
	import gasp_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;
	logic    idle, in_acc, search_go;

	// only the idle sequencer takes words
	assign in_stall  = !idle;
	assign in_acc    = in_valid && idle;
	assign search_go = in_acc && (in_word.action == ACT_SEARCH);

	gasp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.search_go (search_go),
		.sts       (sts),
		.cmd       (cmd),
		.idle      (idle)
	);

	gasp_dp #(.GRID_DIM(GRID_DIM)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.in_word   (in_word),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_word  (out_word)
	);

	// a search word always starts a busy period
	a_search_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_word.action == ACT_SEARCH |=> in_stall)
		else $error("search accepted but core not busy");

	// the no-path word is always the final word
	a_nopath_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.found |-> out_word.last)
		else $error("no-path word without last");

	// no new word is taken while a path is partly delivered
	a_path_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last |-> in_stall)
		else $error("input taken during path emission");
endmodule
`default_nettype wire
